// ----- hw/rtl/adc_trimmed_mean_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ADC_TRIMMED_MEAN_MACROS_SVH
`define ADC_TRIMMED_MEAN_MACROS_SVH

// implication that must hold on every clock edge outside reset
`define ATM_ASSERT_IMPLY(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("adc_trimmed_mean check failed");

// condition that must never be true outside reset
`define ATM_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("adc_trimmed_mean check failed");

`endif

// ----- hw/rtl/atm_pkg.sv -----
// constants, types and sequencer states of the trimmed mean block
// no dependencies
package atm_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int SAMPLE_COUNT = 16;
    localparam int TRIM_COUNT   = 4;
    localparam int TRIM_EFF     = (2 * TRIM_COUNT >= SAMPLE_COUNT) ?
                                  (SAMPLE_COUNT - 1) / 2 : TRIM_COUNT;
    localparam int MID_COUNT    = SAMPLE_COUNT - 2 * TRIM_EFF;
    localparam int IDX_W        = $clog2(SAMPLE_COUNT);
    localparam int SUM_W        = SAMPLE_W + IDX_W;

    // exact divide by MID_COUNT for any sum below 2**SUM_W
    localparam int DIV_SHIFT    = SUM_W + $clog2(MID_COUNT);
    localparam int RECIP_W      = SUM_W + 1;
    localparam logic [RECIP_W-1:0] MID_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(MID_COUNT) - 64'd1) / 64'(MID_COUNT));

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [SUM_W-1:0]    t_sum;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } t_atm_state;

endpackage

// ----- hw/rtl/atm_stream_if.sv -----
// valid/ready stream interfaces for sample input and mean output beats
// depends on atm_pkg
interface atm_sample_if;
    import atm_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample_mv;
    modport source (output valid, output sample_mv, input ready);
    modport sink (input valid, input sample_mv, output ready);
endinterface

interface atm_mean_if;
    import atm_pkg::*;
    logic    valid;
    logic    ready;
    t_sample mean_mv;
    modport source (output valid, output mean_mv, input ready);
    modport sink (input valid, input mean_mv, output ready);
endinterface

// ----- hw/rtl/adc_trimmed_mean.sv -----
// operation: a sample beat is taken in idle, then an insertion walk places it in the sorted set
// the beat that completes a set then sums the MID_COUNT middle samples and scales the sum by
// a reciprocal; the mean beat is held until taken
// no new sample is taken until the walk ends, nor after the last beat of a set until the mean
// beat is taken; the walk is limited by its single compare and store port
// reset: synchronous active-low i_rst_n empties the set and returns to idle
module adc_trimmed_mean (
    input  logic i_clk,
    input  logic i_rst_n,
    atm_sample_if.sink i_sample,
    atm_mean_if.source o_mean
);
    import atm_pkg::*;

    t_atm_state r_state, n_state;
    t_sample    r_store [SAMPLE_COUNT];
    t_sample    r_sample;
    t_idx       r_pos;
    t_idx       r_fill;
    t_idx       r_idx;
    t_sum       r_sum;

    t_idx                     rd_addr;
    t_sample                  rd_data;
    logic                     walk_shift;
    logic                     last_fill;
    logic                     last_sum;
    logic [SUM_W+RECIP_W-1:0] scaled;
    logic                     accept;

    assign accept     = i_sample.valid && i_sample.ready;
    assign rd_addr    = (r_state == ST_WALK) ? r_pos - 1'b1 : r_idx;
    assign rd_data    = r_store[rd_addr];
    assign walk_shift = (r_pos != '0) && (rd_data > r_sample);
    assign last_fill  = r_fill == IDX_W'(SAMPLE_COUNT - 1);
    assign last_sum   = r_idx == IDX_W'(SAMPLE_COUNT - TRIM_EFF - 1);
    assign scaled     = (SUM_W+RECIP_W)'(r_sum) * (SUM_W+RECIP_W)'(MID_RECIP);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_WALK;
            ST_WALK: begin
                if (!walk_shift) n_state = last_fill ? ST_SUM : ST_IDLE;
            end
            ST_SUM:  if (last_sum) n_state = ST_DIV;
            ST_DIV:  n_state = ST_OUT;
            ST_OUT:  if (o_mean.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_sample.ready = (r_state == ST_IDLE);
        o_mean.valid   = (r_state == ST_OUT);
        o_mean.mean_mv = r_sum[SAMPLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_WALK && !walk_shift) begin
                r_fill <= last_fill ? '0 : r_fill + 1'b1;
            end
        end
    end

    // datapath: insertion walk, middle sum, reciprocal scaling
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_sample <= i_sample.sample_mv;
                r_pos    <= r_fill;
            end
            ST_WALK: begin
                if (walk_shift) begin
                    r_store[r_pos] <= rd_data;
                    r_pos          <= r_pos - 1'b1;
                end else begin
                    r_store[r_pos] <= r_sample;
                    r_idx          <= IDX_W'(TRIM_EFF);
                    r_sum          <= '0;
                end
            end
            ST_SUM: begin
                r_sum <= r_sum + SUM_W'(rd_data);
                r_idx <= r_idx + 1'b1;
            end
            ST_DIV: begin
                r_sum <= SUM_W'(scaled >> DIV_SHIFT);
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- hw/rtl/atm_checker.sv -----
// port-level checks of the trimmed mean block, bound to the top level
// depends on adc_trimmed_mean_macros.svh, atm_pkg and adc_trimmed_mean
`include "adc_trimmed_mean_macros.svh"

module atm_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [atm_pkg::SAMPLE_W-1:0] i_mean_mv
);
    import atm_pkg::*;

    // a held mean beat keeps its value
    `ATM_ASSERT_IMPLY(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_mean_mv))
    // the block never takes a sample while a mean beat is pending
    `ATM_ASSERT_NEVER(a_no_overlap, i_clk, i_rst_n, i_in_ready && i_out_valid)
    // ready drops right after every accepted sample, while the walk runs
    `ATM_ASSERT_IMPLY(a_busy_after_in, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)
    // a mean beat is never offered right after a sample beat
    `ATM_ASSERT_IMPLY(a_no_quick_out, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_out_valid)

endmodule

bind adc_trimmed_mean atm_checker u_atm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_mean.valid),
    .i_out_ready (o_mean.ready),
    .i_mean_mv   (o_mean.mean_mv)
);

// ----- tb/tb_adc_trimmed_mean.sv -----
`timescale 1ns / 1ps
// testbench for adc_trimmed_mean: sends sample beats with random gaps, keeps a sorted copy
// of each set to predict its trimmed mean and checks every mean beat against it
// depends on atm_pkg, atm_stream_if and adc_trimmed_mean
module tb_adc_trimmed_mean;
    import atm_pkg::*;

    localparam int TRIM_USED    = (2 * TRIM_COUNT >= SAMPLE_COUNT) ?
                                  (SAMPLE_COUNT - 1) / 2 : TRIM_COUNT;
    localparam int KEPT_COUNT   = SAMPLE_COUNT - 2 * TRIM_USED;
    localparam int MAX_WAIT     = 12;
    localparam int RANDOM_ITEMS = 1400;
    localparam int SETTLE_CYCLES = 4 * SAMPLE_COUNT + 64;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TIMEOUT_NS   = 500000;
    localparam int REPORT_LIMIT = 10;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_NEAR,
        SPREAD_RAILS,
        SPREAD_LOW
    } t_spread;

    logic i_clk = 1'b0;
    logic i_rst_n;

    atm_sample_if sample_if ();
    atm_mean_if   mean_if ();

    adc_trimmed_mean i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if),
        .o_mean   (mean_if)
    );

    t_sample set_sorted [SAMPLE_COUNT];
    int      set_fill = 0;
    t_sample expected_means [$];
    int      error_count = 0;
    bit      send_no_gaps = 1'b0;
    bit      take_no_stalls = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int draw_wait(bit no_wait);
        return no_wait ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void note_failure(string msg);
        if (error_count < REPORT_LIMIT)
            $display("mismatch: %s", msg);
        error_count++;
    endfunction

    // insertion walk into the current set, mean of the middle once the set is full
    function automatic void record_sample(t_sample value);
        int          pos;
        int unsigned total;
        pos = set_fill;
        while (pos > 0 && set_sorted[pos-1] > value) begin
            set_sorted[pos] = set_sorted[pos-1];
            pos--;
        end
        set_sorted[pos] = value;
        set_fill++;
        if (set_fill == SAMPLE_COUNT) begin
            total = 0;
            for (int i = TRIM_USED; i < SAMPLE_COUNT - TRIM_USED; i++)
                total += set_sorted[i];
            expected_means.push_back(t_sample'(total / KEPT_COUNT));
            set_fill = 0;
        end
    endfunction

    task automatic send_sample(t_sample value);
        int gap;
        gap = draw_wait(send_no_gaps);
        if (gap > 0) begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_if.valid     <= 1'b1;
        sample_if.sample_mv <= value;
        do @(posedge i_clk); while (sample_if.ready !== 1'b1);
        record_sample(value);
    endtask

    function automatic t_sample draw_sample(t_spread spread, t_sample base);
        case (spread)
            SPREAD_NEAR:  return base + t_sample'($urandom_range(0, 63));
            SPREAD_RAILS: return $urandom_range(0, 1) ? '1 : '0;
            SPREAD_LOW:   return t_sample'($urandom_range(0, 15));
            default:      return t_sample'($urandom);
        endcase
    endfunction

    // twelve full-scale readings and four zeros, interleaved so zeros walk far
    task automatic test_rails();
        for (int i = 0; i < SAMPLE_COUNT; i++)
            send_sample((i % 4 == 3) ? '0 : '1);
    endtask

    // descending readings with a tie, left open for the random part to finish
    task automatic test_walk();
        send_sample(16'd40000);
        send_sample(16'd30000);
        send_sample(16'd30000);
        send_sample(16'd20000);
        send_sample(16'd10000);
        send_sample(16'd5);
        send_sample(16'd1);
        send_sample(16'd0);
    endtask

    task automatic test_random();
        int      sent;
        t_spread spread;
        t_sample base;
        sent   = 0;
        spread = SPREAD_FULL;
        base   = '0;
        while (sent < RANDOM_ITEMS || set_fill != 0) begin
            if (set_fill == 0) begin
                spread = t_spread'($urandom_range(0, 3));
                base   = t_sample'($urandom);
                if ($urandom_range(0, 7) == 0)
                    send_no_gaps = ~send_no_gaps;
                if ($urandom_range(0, 7) == 0)
                    take_no_stalls = ~take_no_stalls;
            end
            send_sample(draw_sample(spread, base));
            sent++;
        end
        send_no_gaps   = 1'b0;
        take_no_stalls = 1'b0;
    endtask

    // mean beat sink with random stalls
    initial begin
        int      stall;
        t_sample want;
        mean_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = draw_wait(take_no_stalls);
            if (stall > 0) begin
                mean_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            mean_if.ready <= 1'b1;
            do @(posedge i_clk); while (mean_if.valid !== 1'b1);
            if (expected_means.size() == 0) begin
                note_failure($sformatf("unexpected mean beat %0d", mean_if.mean_mv));
            end else begin
                want = expected_means.pop_front();
                if (mean_if.mean_mv !== want)
                    note_failure($sformatf("mean_mv expected %0d actual %0d",
                                           want, mean_if.mean_mv));
            end
        end
    end

    initial begin
        int drain;
        i_rst_n             <= 1'b0;
        sample_if.valid     <= 1'b0;
        sample_if.sample_mv <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_rails();
        test_walk();
        test_random();
        sample_if.valid <= 1'b0;

        drain = 0;
        while (expected_means.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_means.size() != 0)
            note_failure($sformatf("%0d mean beats never arrived", expected_means.size()));

        if (error_count == 0) begin
            $display("adc_trimmed_mean verification clean");
        end else begin
            $display("adc_trimmed_mean verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("adc_trimmed_mean verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/atm_pkg.sv
hw/rtl/atm_stream_if.sv
hw/rtl/adc_trimmed_mean.sv
hw/rtl/atm_checker.sv
tb/tb_adc_trimmed_mean.sv
